>>> hdl/fit_partition_allocator_macros.svh
// Assertion macros for the fit partition allocator.
// Included by the top level; relies on nothing else.
`ifndef FIT_PARTITION_ALLOCATOR_MACROS_SVH
`define FIT_PARTITION_ALLOCATOR_MACROS_SVH

// Same-cycle implication, reset masked
`define FPA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, reset masked
`define FPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/fpa_pkg.sv
// Shared types and constants of the fit partition allocator.
// No dependencies; imported by the controller, datapath and top level.
package fpa_pkg;

   localparam int DEF_MAX_SEGMENTS = 32;
   localparam int DEF_WAIT_DEPTH   = 16;

   localparam logic [11:0] RESET_TOTAL = 12'd2000;
   localparam logic [11:0] RESET_MIN   = 12'd100;
   localparam logic [11:0] RESET_MAX   = 12'd2000;

   // register indexes
   localparam logic [1:0] CSR_TOTAL = 2'd0;
   localparam logic [1:0] CSR_MODE  = 2'd1;
   localparam logic [1:0] CSR_MIN   = 2'd2;
   localparam logic [1:0] CSR_MAX   = 2'd3;

   // status codes
   localparam logic [1:0] ST_PLACED  = 2'd0;
   localparam logic [1:0] ST_QUEUED  = 2'd1;
   localparam logic [1:0] ST_IGNORED = 2'd2;
   localparam logic [1:0] ST_DROPPED = 2'd3;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_MAP    = 1'b1;
   localparam logic REQ_ARRIVAL = 1'b0;
   localparam logic REQ_TICK    = 1'b1;
   localparam logic FIT_BEST    = 1'b0;
   localparam logic FIT_WORST   = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  proc_id;
      logic [11:0] req_size;
      logic [15:0] run_time;
   } req_item_type;

   typedef struct packed {
      logic        result_kind;
      logic [1:0]  status;
      logic [11:0] seg_start;
      logic [11:0] seg_size;
      logic [7:0]  seg_owner;
      logic        seg_free;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic        hole;
      logic [7:0]  owner;
      logic [15:0] left;
      logic [11:0] size;
   } seg_entry_type;

   typedef struct packed {
      logic [7:0]  id;
      logic [11:0] size;
      logic [15:0] time_left;
   } wait_entry_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SCAN_INIT,
      OP_HEAD_INIT,
      OP_SCAN_STEP,
      OP_PLACE,
      OP_MERGE_INIT,
      OP_MERGE_STEP,
      OP_AGE_STEP,
      OP_EMIT_STEP,
      OP_PUSH,
      OP_POP,
      OP_SET_STATUS
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       first_fit;
      logic       map_sel;
      logic [1:0] status;
   } dp_cmd_type;

   typedef struct packed {
      logic walk_done;
      logic walk_last;
      logic pick_valid;
      logic size_ok;
      logic queue_full;
      logic queue_empty;
      logic head_oversize;
   } dp_stat_type;

endpackage

>>> hdl/fpa_ctrl.sv
// Sequencer of the fit partition allocator: walks arrivals, ticks and queue retries.
// Depends on fpa_pkg; drives the datapath through dp_cmd_type.
module fpa_ctrl import fpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_type,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_FIND, S_MERGE, S_STATUS, S_EMIT, S_AGE, S_QHEAD, S_QEVAL
   } state_type;

   typedef enum logic [1:0] {
      CTX_ARRIVE, CTX_TICK, CTX_RETRY
   } ctx_type;

   state_type state_ff, state_in;
   ctx_type   ctx_ff, ctx_in;

   // next state and datapath command
   always_comb begin
      state_in      = state_ff;
      ctx_in        = ctx_ff;
      cmd.op        = OP_NONE;
      cmd.first_fit = (ctx_ff == CTX_RETRY);
      cmd.map_sel   = (state_ff == S_EMIT);
      cmd.status    = ST_PLACED;
      req_stall     = (state_ff != S_IDLE);
      rsp_valid     = (state_ff == S_STATUS) || (state_ff == S_EMIT);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_LOAD;
               if (req_type == REQ_TICK) begin
                  state_in = S_EMIT;
                  ctx_in   = CTX_TICK;
               end else begin
                  state_in = S_CHECK;
                  ctx_in   = CTX_ARRIVE;
               end
            end
         end
         S_CHECK: begin
            if (stat.size_ok) begin
               cmd.op   = OP_SCAN_INIT;
               state_in = S_FIND;
            end else begin
               cmd.op     = OP_SET_STATUS;
               cmd.status = ST_IGNORED;
               state_in   = S_STATUS;
            end
         end
         S_FIND: begin
            priority if (!stat.walk_done) begin
               cmd.op = OP_SCAN_STEP;
            end else if (stat.pick_valid) begin
               cmd.op   = OP_PLACE;
               state_in = S_MERGE;
            end else if (ctx_ff == CTX_RETRY) begin
               state_in = S_IDLE;
            end else if (!stat.queue_full) begin
               cmd.op   = OP_PUSH;
               state_in = S_STATUS;
            end else begin
               cmd.op     = OP_SET_STATUS;
               cmd.status = ST_DROPPED;
               state_in   = S_STATUS;
            end
         end
         S_MERGE: begin
            if (!stat.walk_done) begin
               cmd.op = OP_MERGE_STEP;
            end else begin
               unique case (ctx_ff)
                  CTX_ARRIVE: state_in = S_STATUS;
                  CTX_TICK: begin
                     ctx_in   = CTX_RETRY;
                     state_in = S_QHEAD;
                  end
                  default: begin
                     cmd.op   = OP_POP;
                     state_in = S_QHEAD;
                  end
               endcase
            end
         end
         S_STATUS: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         S_EMIT: begin
            if (!rsp_stall) begin
               if (stat.walk_last) begin
                  cmd.op   = OP_SCAN_INIT;
                  state_in = S_AGE;
               end else begin
                  cmd.op = OP_EMIT_STEP;
               end
            end
         end
         S_AGE: begin
            if (!stat.walk_done) begin
               cmd.op = OP_AGE_STEP;
            end else begin
               cmd.op   = OP_MERGE_INIT;
               state_in = S_MERGE;
            end
         end
         S_QHEAD: begin
            // head entry read lands in the next cycle
            state_in = stat.queue_empty ? S_IDLE : S_QEVAL;
         end
         S_QEVAL: begin
            if (stat.head_oversize) begin
               cmd.op   = OP_POP;
               state_in = S_QHEAD;
            end else begin
               cmd.op   = OP_HEAD_INIT;
               state_in = S_FIND;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ctx_ff   <= CTX_ARRIVE;
      end else begin
         state_ff <= state_in;
         ctx_ff   <= ctx_in;
      end
   end

endmodule

>>> hdl/fpa_datapath.sv
// Segment list, wait queue and configuration registers of the allocator.
// Depends on fpa_pkg; steered one step a cycle by fpa_ctrl, unless a stalled result holds it.
module fpa_datapath import fpa_pkg::*; #(
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
   parameter int WAIT_DEPTH   = DEF_WAIT_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  req_item_type req_data,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [11:0]  csr_wdata,
   input  dp_cmd_type   cmd,
   output dp_stat_type  stat,
   output rsp_item_type rsp_data
);

   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int NW = $clog2(MAX_SEGMENTS + 1);
   localparam int HW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int CW = $clog2(WAIT_DEPTH + 1);
   localparam int SW = CW + 1;

   seg_entry_type  seg_ff [MAX_SEGMENTS];
   wait_entry_type wait_mem [WAIT_DEPTH];
   wait_entry_type rd_ff;

   logic [NW-1:0] count_ff, idx_ff;
   logic [11:0]   total_ff, min_ff, max_ff;
   logic          mode_ff;
   logic [HW-1:0] head_ff;
   logic [CW-1:0] wcount_ff;
   logic [7:0]    rq_id_ff;
   logic [11:0]   rq_size_ff;
   logic [15:0]   rq_time_ff;
   logic [11:0]   start_ff, at_ff, best_ff, pick_start_ff, acc_ff;
   logic [IW-1:0] pick_ix_ff;
   logic          pick_v_ff, prev_hole_ff;
   logic [1:0]    status_ff;

   logic [IW-1:0] idx_ix, prev_ix, pick_nx;
   seg_entry_type cur;
   logic          fit_ok, take, merge_now, split;
   logic [11:0]   cur_left, merge_sum;
   logic [15:0]   age_left, in_time;
   logic [SW-1:0] tail_sum;
   logic [HW-1:0] tail_ix, head_nx;

   assign idx_ix  = idx_ff[IW-1:0];
   assign prev_ix = IW'(idx_ff - NW'(1));
   assign pick_nx = pick_ix_ff + IW'(1);
   assign cur     = seg_ff[idx_ix];

   // fit test for the entry under the walk pointer
   assign fit_ok   = cur.hole && (rq_size_ff <= cur.size) &&
                     ((rq_size_ff == cur.size) || (count_ff < NW'(MAX_SEGMENTS)));
   assign cur_left = cur.size - rq_size_ff;
   assign take     = fit_ok && (!pick_v_ff ||
                     (!cmd.first_fit && (((mode_ff == FIT_BEST) && (cur_left < best_ff)) ||
                                         ((mode_ff == FIT_WORST) && (cur_left > best_ff)))));
   assign split     = (best_ff != 12'd0);
   assign merge_now = prev_hole_ff && cur.hole;
   assign merge_sum = acc_ff + cur.size;
   assign age_left  = (cur.left != 16'd0) ? cur.left - 16'd1 : 16'd0;
   assign in_time   = (req_data.run_time == 16'd0) ? 16'd1 : req_data.run_time;

   // queue pointers
   assign tail_sum = SW'(head_ff) + SW'(wcount_ff);
   assign tail_ix  = (tail_sum >= SW'(WAIT_DEPTH)) ? HW'(tail_sum - SW'(WAIT_DEPTH))
                                                   : HW'(tail_sum);
   assign head_nx  = (head_ff == HW'(WAIT_DEPTH - 1)) ? '0 : head_ff + HW'(1);

   // status to the controller
   assign stat.walk_done     = (idx_ff >= count_ff);
   assign stat.walk_last     = ((idx_ff + NW'(1)) == count_ff);
   assign stat.pick_valid    = pick_v_ff;
   assign stat.size_ok       = (rq_size_ff >= min_ff) && (rq_size_ff <= max_ff);
   assign stat.queue_full    = (wcount_ff == CW'(WAIT_DEPTH));
   assign stat.queue_empty   = (wcount_ff == '0);
   assign stat.head_oversize = (rd_ff.size > total_ff);

   // result payload: map segment or arrival status
   always_comb begin
      if (cmd.map_sel) begin
         rsp_data.result_kind = KIND_MAP;
         rsp_data.status      = ST_PLACED;
         rsp_data.seg_start   = start_ff;
         rsp_data.seg_size    = cur.size;
         rsp_data.seg_owner   = cur.owner;
         rsp_data.seg_free    = cur.hole;
         rsp_data.last        = stat.walk_last;
      end else begin
         rsp_data.result_kind = KIND_STATUS;
         rsp_data.status      = status_ff;
         rsp_data.seg_start   = at_ff;
         rsp_data.seg_size    = rq_size_ff;
         rsp_data.seg_owner   = rq_id_ff;
         rsp_data.seg_free    = 1'b0;
         rsp_data.last        = 1'b1;
      end
   end

   // wait queue storage, head read registered
   always_ff @(posedge clock) begin
      if (cmd.op == OP_PUSH) begin
         wait_mem[tail_ix] <= '{id: rq_id_ff, size: rq_size_ff, time_left: rq_time_ff};
      end
      rd_ff <= wait_mem[head_ff];
   end

   // segment list, walk registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff  <= RESET_TOTAL;
         mode_ff   <= FIT_BEST;
         min_ff    <= RESET_MIN;
         max_ff    <= RESET_MAX;
         seg_ff[0] <= '{hole: 1'b1, owner: 8'd0, left: 16'd0, size: RESET_TOTAL};
         count_ff  <= NW'(1);
         head_ff   <= '0;
         wcount_ff <= '0;
         idx_ff    <= '0;
         pick_v_ff <= 1'b0;
         prev_hole_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TOTAL: begin
               total_ff  <= csr_wdata;
               seg_ff[0] <= '{hole: 1'b1, owner: 8'd0, left: 16'd0, size: csr_wdata};
               count_ff  <= NW'(1);
               head_ff   <= '0;
               wcount_ff <= '0;
            end
            CSR_MODE: mode_ff <= csr_wdata[0];
            CSR_MIN:  min_ff  <= csr_wdata;
            CSR_MAX:  max_ff  <= csr_wdata;
            default: ;
         endcase
      end else begin
         unique case (cmd.op)
            OP_LOAD: begin
               rq_id_ff   <= req_data.proc_id;
               rq_size_ff <= req_data.req_size;
               rq_time_ff <= in_time;
               at_ff      <= 12'd0;
               idx_ff     <= '0;
               start_ff   <= 12'd0;
            end
            OP_SCAN_INIT: begin
               idx_ff    <= '0;
               start_ff  <= 12'd0;
               pick_v_ff <= 1'b0;
            end
            OP_HEAD_INIT: begin
               rq_id_ff   <= rd_ff.id;
               rq_size_ff <= rd_ff.size;
               rq_time_ff <= rd_ff.time_left;
               idx_ff     <= '0;
               start_ff   <= 12'd0;
               pick_v_ff  <= 1'b0;
            end
            OP_SCAN_STEP: begin
               if (take) begin
                  pick_v_ff     <= 1'b1;
                  pick_ix_ff    <= idx_ix;
                  best_ff       <= cur_left;
                  pick_start_ff <= start_ff;
               end
               start_ff <= start_ff + cur.size;
               idx_ff   <= idx_ff + NW'(1);
            end
            OP_PLACE: begin
               // open a slot after the pick for the leftover hole
               for (int j = 1; j < MAX_SEGMENTS; j++) begin
                  if (split && (j > int'(pick_ix_ff) + 1)) seg_ff[j] <= seg_ff[j-1];
               end
               if (split) begin
                  seg_ff[pick_nx] <= '{hole: 1'b1, owner: 8'd0, left: 16'd0, size: best_ff};
                  count_ff        <= count_ff + NW'(1);
               end
               seg_ff[pick_ix_ff] <= '{hole: 1'b0, owner: rq_id_ff, left: rq_time_ff,
                                       size: rq_size_ff};
               at_ff        <= pick_start_ff;
               status_ff    <= ST_PLACED;
               idx_ff       <= '0;
               prev_hole_ff <= 1'b0;
            end
            OP_MERGE_INIT: begin
               idx_ff       <= '0;
               prev_hole_ff <= 1'b0;
            end
            OP_MERGE_STEP: begin
               if (merge_now) begin
                  // fold this hole into the previous one and close the gap
                  for (int j = 0; j < MAX_SEGMENTS - 1; j++) begin
                     if (j >= int'(idx_ff)) seg_ff[j] <= seg_ff[j+1];
                  end
                  seg_ff[prev_ix].size <= merge_sum;
                  acc_ff   <= merge_sum;
                  count_ff <= count_ff - NW'(1);
               end else begin
                  prev_hole_ff <= cur.hole;
                  acc_ff       <= cur.size;
                  idx_ff       <= idx_ff + NW'(1);
               end
            end
            OP_AGE_STEP: begin
               if (!cur.hole) begin
                  seg_ff[idx_ix].left <= age_left;
                  if (age_left == 16'd0) begin
                     seg_ff[idx_ix].hole  <= 1'b1;
                     seg_ff[idx_ix].owner <= 8'd0;
                  end
               end
               idx_ff <= idx_ff + NW'(1);
            end
            OP_EMIT_STEP: begin
               start_ff <= start_ff + cur.size;
               idx_ff   <= idx_ff + NW'(1);
            end
            OP_PUSH: begin
               wcount_ff <= wcount_ff + CW'(1);
               status_ff <= ST_QUEUED;
            end
            OP_POP: begin
               head_ff   <= head_nx;
               wcount_ff <= wcount_ff - CW'(1);
            end
            OP_SET_STATUS: status_ff <= cmd.status;
            OP_NONE: ;
            default: ;
         endcase
      end
   end

endmodule

>>> hdl/fit_partition_allocator.sv
// Top level of the best/worst fit variable partition allocator.
// Depends on fpa_pkg, fpa_ctrl, fpa_datapath and the assertion macro header.
//
//   channel  | direction | handshake          | payload
//   req_     | in        | req_valid/req_stall | req_item_type
//   rsp_     | out       | rsp_valid/rsp_stall | rsp_item_type
//   csr_     | in        | csr_we             | csr_index, csr_wdata
//
// One transaction at a time; req_stall stays high from acceptance until the sequencer is idle
// again, which for a tick includes aging, merging and queue retries after the last result.
// An arrival over N segments scans the list for a hole, then, when placed, walks the list to merge
// neighbouring holes and gives one status result. A tick gives N map results, takes N aging steps
// and the merge walk, then for each queue retry a scan and the merge walk again; all are set by
// the single-entry walk over the segment list.
// Reset is synchronous; it restores the registers and a single hole, no clearing pass.
// A stalled result holds the sequencer in place until rsp_stall drops.
`include "fit_partition_allocator_macros.svh"

module fit_partition_allocator import fpa_pkg::*; #(
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
   parameter int WAIT_DEPTH   = DEF_WAIT_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [11:0]  csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        req_take, rsp_take, rsp_is_status;

   fpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_data.req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   fpa_datapath #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .WAIT_DEPTH   (WAIT_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

   // handshake terms for the checks
   assign req_take      = req_valid && !req_stall;
   assign rsp_take      = rsp_valid && !rsp_stall;
   assign rsp_is_status = rsp_valid && (rsp_data.result_kind == KIND_STATUS);

   // checks on sequencing
   `FPA_ASSERT_NOW(a_idle_no_result, clock, reset, !req_stall, !rsp_valid, "result while idle")
   `FPA_ASSERT_NEXT(a_accept_busy, clock, reset, req_take, req_stall, "no busy after accept")
   `FPA_ASSERT_NOW(a_status_last, clock, reset, rsp_is_status, rsp_data.last, "status not last")
   `FPA_ASSERT_NEXT(a_status_done, clock, reset, rsp_take && rsp_is_status, !req_stall, "busy")

endmodule
